[sv/hst_pkg.sv]
// Shared types, constants and the CORDIC arctangent table for the heading slew tracker.
package hst_pkg;

  localparam int unsigned COORD_BITS   = 10;
  localparam int unsigned CORDIC_STEPS = 16;
  localparam int unsigned CW           = COORD_BITS + 1;   // signed coordinate difference
  localparam int unsigned XW           = CW + 16 + 3;      // CORDIC x/y, scaled by 2^16
  localparam int unsigned ZW           = 25;               // angle accumulator, 1/32768 deg
  localparam int unsigned AW           = ZW - 8;           // angle, 1/128 deg, signed
  localparam int unsigned HW           = 16;               // heading width
  localparam int unsigned QUEUE_DEPTH  = 4;                // power of two
  localparam int unsigned QPW          = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCW          = $clog2(QUEUE_DEPTH + 1);

  localparam int unsigned FULL_TURN    = 46080;
  localparam int unsigned HALF_TURN    = 23040;
  localparam int unsigned Z_QUARTER    = 90 * 32768;

  localparam logic [1:0] CFG_CENTER_X = 2'd0;
  localparam logic [1:0] CFG_CENTER_Y = 2'd1;
  localparam logic [1:0] CFG_MAX_RATE = 2'd2;

  typedef struct packed {
    logic [COORD_BITS-1:0] center_x;
    logic [COORD_BITS-1:0] center_y;
    logic [15:0]           max_rate;
  } hst_cfg_t;

  typedef struct packed {
    logic                 upd;
    logic signed [AW-1:0] target;
    logic [15:0]          step;
  } hst_item_t;

  // atan(2^-i) in 1/32768 degree
  function automatic logic signed [ZW-1:0] atan_lut(input int unsigned i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = ZW'(1474560);
      1:  r = ZW'(870484);
      2:  r = ZW'(459940);
      3:  r = ZW'(233473);
      4:  r = ZW'(117189);
      5:  r = ZW'(58652);
      6:  r = ZW'(29333);
      7:  r = ZW'(14667);
      8:  r = ZW'(7334);
      9:  r = ZW'(3667);
      10: r = ZW'(1833);
      11: r = ZW'(917);
      12: r = ZW'(458);
      13: r = ZW'(229);
      14: r = ZW'(115);
      15: r = ZW'(57);
      16: r = ZW'(29);
      17: r = ZW'(14);
      18: r = ZW'(7);
      19: r = ZW'(4);
      20: r = ZW'(2);
      21: r = ZW'(1);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[sv/hst_front.sv]
// Front end: accepts items, tracks the target point and runs the pipelined CORDIC atan2.
module hst_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  hst_pkg::hst_cfg_t             cfg_i,
  input  logic                          push,
  output logic                          full,
  input  logic                          func_i,
  input  logic [hst_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic [hst_pkg::COORD_BITS-1:0] pos_y_i,
  input  logic [15:0]                   dt_ticks_i,
  input  logic                          q_full_i,
  output logic                          q_push_o,
  output hst_pkg::hst_item_t            q_item_o
);
  import hst_pkg::*;

  localparam int unsigned NS = CORDIC_STEPS;

  logic [COORD_BITS-1:0] held_x_q, held_y_q;
  logic                  moved_q;
  logic                  adv, accept;

  logic                  v_q    [NS+2];
  logic                  upd_q  [NS+1];
  logic                  zero_q [NS+1];
  logic [15:0]           step_q [NS+1];
  logic signed [XW-1:0]  x_q    [NS+1];
  logic signed [XW-1:0]  y_q    [NS+1];
  logic signed [ZW-1:0]  z_q    [NS+1];
  hst_item_t             out_q;

  assign adv      = !(v_q[NS+1] && q_full_i);
  assign full     = !adv;
  assign accept   = push && adv;
  assign q_push_o = v_q[NS+1] && !q_full_i;
  assign q_item_o = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_x_q <= '0;
      held_y_q <= '0;
      moved_q  <= 1'b0;
    end else if (accept && !func_i) begin
      held_x_q <= pos_x_i;
      held_y_q <= pos_y_i;
      moved_q  <= 1'b1;
    end
  end

  // entry stage: differences, quadrant pre-rotation, step product
  logic signed [CW-1:0] dx, dy, px, py;
  logic signed [ZW-1:0] pz;
  logic [31:0]          prod;

  always_comb begin
    dx   = $signed({1'b0, held_x_q}) - $signed({1'b0, cfg_i.center_x});
    dy   = $signed({1'b0, held_y_q}) - $signed({1'b0, cfg_i.center_y});
    px   = dx;
    py   = dy;
    pz   = '0;
    if (dx < 0) begin
      if (dy >= 0) begin
        px = dy;
        py = -dx;
        pz = ZW'(Z_QUARTER);
      end else begin
        px = -dy;
        py = dx;
        pz = -ZW'(Z_QUARTER);
      end
    end
    prod = cfg_i.max_rate * dt_ticks_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= push;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      upd_q[0]  <= func_i && moved_q;
      zero_q[0] <= (dx == 0) && (dy == 0);
      step_q[0] <= prod[31:16];
      x_q[0]    <= $signed({{(XW-CW-16){px[CW-1]}}, px, 16'h0000});
      y_q[0]    <= $signed({{(XW-CW-16){py[CW-1]}}, py, 16'h0000});
      z_q[0]    <= pz;
    end
  end

  // CORDIC vectoring stages
  for (genvar i = 0; i < NS; i++) begin : g_stage
    logic signed [XW-1:0] xs, ys, xn, yn;
    logic signed [ZW-1:0] zn;

    always_comb begin
      xs = x_q[i] >>> i;
      ys = y_q[i] >>> i;
      if (y_q[i] > 0) begin
        xn = x_q[i] + ys;
        yn = y_q[i] - xs;
        zn = z_q[i] + atan_lut(i);
      end else begin
        xn = x_q[i] - ys;
        yn = y_q[i] + xs;
        zn = z_q[i] - atan_lut(i);
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[i+1] <= 1'b0;
      end else if (adv) begin
        v_q[i+1] <= v_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        upd_q[i+1]  <= upd_q[i];
        zero_q[i+1] <= zero_q[i];
        step_q[i+1] <= step_q[i];
        x_q[i+1]    <= xn;
        y_q[i+1]    <= yn;
        z_q[i+1]    <= zn;
      end
    end
  end

  // round to 1/128 degree and wrap into (-180, 180]
  logic signed [ZW-1:0]  zr;
  logic signed [AW:0]    a;
  logic signed [AW-1:0]  tgt;

  always_comb begin
    zr = z_q[NS] + ZW'(128);
    a  = {zr[ZW-1], zr[ZW-1:8]};
    if (a > $signed((AW+1)'(HALF_TURN))) begin
      a = a - $signed((AW+1)'(FULL_TURN));
    end
    if (a <= -$signed((AW+1)'(HALF_TURN))) begin
      a = a + $signed((AW+1)'(FULL_TURN));
    end
    tgt = zero_q[NS] ? '0 : a[AW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[NS+1] <= 1'b0;
    end else if (adv) begin
      v_q[NS+1] <= v_q[NS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q.upd    <= upd_q[NS];
      out_q.target <= tgt;
      out_q.step   <= step_q[NS];
    end
  end

endmodule

[sv/hst_queue.sv]
// Short queue of classified items between the front end and the heading update.
module hst_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  hst_pkg::hst_item_t item_i,
  output logic               full_o,
  input  logic               pop_i,
  output logic               empty_o,
  output hst_pkg::hst_item_t item_o
);
  import hst_pkg::*;

  hst_item_t        mem_q [QUEUE_DEPTH];
  logic [QPW-1:0]   wptr_q, rptr_q;
  logic [QCW-1:0]   count_q, count_d;

  assign full_o  = (count_q == QCW'(QUEUE_DEPTH));
  assign empty_o = (count_q == '0);
  assign item_o  = mem_q[rptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + QCW'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - QCW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (push_i) begin
        wptr_q <= wptr_q + QPW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QPW'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= item_i;
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && empty_o))
    else $error("queue pop while empty");

endmodule

[sv/hst_back.sv]
// Back end: wraps and clamps the turn, updates the heading and holds the result register.
module hst_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_empty_i,
  input  hst_pkg::hst_item_t     q_item_i,
  output logic                   q_pop_o,
  output logic                   empty,
  input  logic                   pop,
  output logic [hst_pkg::HW-1:0] heading_o
);
  import hst_pkg::*;

  logic [HW-1:0]     heading_q, heading_d;
  logic [HW-1:0]     res_q;
  logic              res_v_q;
  logic signed [17:0] diff, stp, nh;

  assign q_pop_o   = !q_empty_i && (!res_v_q || pop);
  assign empty     = !res_v_q;
  assign heading_o = res_q;

  always_comb begin
    stp  = $signed({2'b00, q_item_i.step});
    diff = $signed({q_item_i.target[AW-1], q_item_i.target}) - $signed({2'b00, heading_q});
    if (diff > $signed(18'(HALF_TURN))) begin
      diff = diff - $signed(18'(FULL_TURN));
    end
    if (diff <= -$signed(18'(HALF_TURN))) begin
      diff = diff + $signed(18'(FULL_TURN));
    end
    if (diff > stp) begin
      diff = stp;
    end
    if (diff < -stp) begin
      diff = -stp;
    end
    nh = $signed({2'b00, heading_q}) + diff;
    if (nh < 0) begin
      nh = nh + $signed(18'(FULL_TURN));
    end
    if (nh >= $signed(18'(FULL_TURN))) begin
      nh = nh - $signed(18'(FULL_TURN));
    end
    heading_d = q_item_i.upd ? nh[HW-1:0] : heading_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      heading_q <= '0;
      res_v_q   <= 1'b0;
    end else begin
      if (q_pop_o) begin
        heading_q <= heading_d;
        res_v_q   <= 1'b1;
      end else if (pop) begin
        res_v_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      res_q <= heading_d;
    end
  end

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    heading_q < HW'(FULL_TURN))
    else $error("heading out of range");

  a_hold_no_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (q_pop_o && !q_item_i.upd) |=> (heading_q == $past(heading_q)))
    else $error("heading changed on non-update item");

endmodule

[sv/heading_slew_tracker.sv]
// Top level of the heading slew tracker: configuration registers and the front/back pipeline.
//
// Input queue side: func_i selects a target position update (pos_x_i, pos_y_i) or a
// time tick (dt_ticks_i); an item transfers when push is high and full is low.
// Result side: the heading after each item sits on heading_o while empty is low and
// transfers when pop is high. Every input item gives exactly one result, in order.
// Configuration: cfg_valid_i/cfg_ready_o with cfg_index_i (0 center_x, 1 center_y,
// 2 max_rate) and cfg_data_i; cfg_ready_o is always high, other indexes are dropped.
// Throughput: one item per cycle while results are popped as they appear. An item
// passes from the input transfer to the shown result through the CORDIC pipeline
// (entry stage, one stage per iteration, rounding stage), the item queue and the
// result register. The only loop across items is the heading update through heading_q.
// When pop stays low the result register holds, the item queue fills, the CORDIC
// pipeline stops as a whole and full rises; nothing is dropped.
// Reset clears the heading, the held target and the moved flag, and loads the
// configuration registers with center (400, 300) and max_rate 1920.
module heading_slew_tracker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [1:0]                     cfg_index_i,
  input  logic [15:0]                    cfg_data_i,
  input  logic                           push,
  output logic                           full,
  input  logic                           func_i,
  input  logic [hst_pkg::COORD_BITS-1:0] pos_x_i,
  input  logic [hst_pkg::COORD_BITS-1:0] pos_y_i,
  input  logic [15:0]                    dt_ticks_i,
  output logic                           empty,
  input  logic                           pop,
  output logic [hst_pkg::HW-1:0]         heading_o
);
  import hst_pkg::*;

  hst_cfg_t  cfg_q;
  hst_item_t f_item, q_item;
  logic      q_push, q_full, q_pop, q_empty;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.center_x <= COORD_BITS'(400);
      cfg_q.center_y <= COORD_BITS'(300);
      cfg_q.max_rate <= 16'd1920;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_CENTER_X: cfg_q.center_x <= cfg_data_i[COORD_BITS-1:0];
        CFG_CENTER_Y: cfg_q.center_y <= cfg_data_i[COORD_BITS-1:0];
        CFG_MAX_RATE: cfg_q.max_rate <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hst_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .push       (push),
    .full       (full),
    .func_i     (func_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .dt_ticks_i (dt_ticks_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_item_o   (f_item)
  );

  hst_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .item_i  (f_item),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .item_o  (q_item)
  );

  hst_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .q_empty_i (q_empty),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .empty     (empty),
    .pop       (pop),
    .heading_o (heading_o)
  );

endmodule
